>>> rtl/core/grid_occupancy_first_fit_allocator_unit_macros.svh
// Assertion macros for the grid occupancy allocator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef GRID_OCCUPANCY_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define GRID_OCCUPANCY_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define GOFA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GOFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/gofa_pkg.sv
// Shared types, constants and helpers for the grid occupancy allocator.
// No dependencies; imported by the controller, datapath and top level.
package gofa_pkg;

	localparam int NUM_GRIDS  = 4;
	localparam int MAX_ROWS   = 16;
	localparam int MAX_COLS   = 16;
	localparam int GRID_W     = 2;
	localparam int ROW_W      = 4;
	localparam int COL_W      = 4;
	localparam int DIM_W      = 5;
	localparam int ADDR_W     = GRID_W + ROW_W;
	localparam int DEPTH      = NUM_GRIDS * MAX_ROWS;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 5;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [1:0] {
		REQ_MARK  = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_FIND  = 2'd2,
		REQ_CLEAR = 2'd3
	} gofa_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MARK_CHK,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_FIND_ROW,
		ST_FIND_RD,
		ST_FIND_ACC,
		ST_FIND_EVAL,
		ST_RESP
	} gofa_state_t;

	// request payload, lowest field in the lowest bits
	typedef struct packed {
		logic [3:0]       pad;
		logic [DIM_W-1:0] item_cols;
		logic [DIM_W-1:0] item_rows;
		logic [COL_W-1:0] target_col;
		logic [ROW_W-1:0] target_row;
		logic [GRID_W-1:0] target_grid;
	} gofa_in_t;

	typedef struct packed {
		logic [5:0]        pad;
		logic [COL_W-1:0]  found_col;
		logic [ROW_W-1:0]  found_row;
		logic [GRID_W-1:0] found_grid;
	} gofa_out_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;
		logic clear_all;
		logic set_ok;
		logic mark_rd;
		logic mark_wr;
		logic row_inc;
		logic grid_next;
		logic find_start;
		logic find_rd;
		logic find_acc;
		logic set_hit;
		logic load_out;
	} gofa_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic tgt_present;
		logic mark_row_ok;
		logic grid_done;
		logic last_grid;
		logic acc_more;
		logic fit_any;
		logic out_free;
	} gofa_stat_t;

	// dimension register clipped to the grid maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] lim);
		return (v > lim) ? lim : v;
	endfunction

endpackage

>>> rtl/core/gofa_ctrl.sv
// Sequencing state machine of the grid occupancy allocator.
// Depends on gofa_pkg; drives gofa_dp through command and status structs.
module gofa_ctrl import gofa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [1:0]  s_tuser,
	input  gofa_stat_t  stat,
	output gofa_cmd_t   cmd
);

	gofa_state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					case (gofa_req_t'(s_tuser))
						REQ_CLEAR: begin
							cmd.clear_all = 1'b1;
							cmd.set_ok    = 1'b1;
							state_nx      = ST_RESP;
						end
						REQ_FIND: state_nx = ST_FIND_ROW;
						default:  state_nx = ST_MARK_CHK;
					endcase
				end
			end
			ST_MARK_CHK: begin
				if (stat.tgt_present) begin
					cmd.set_ok = 1'b1;
					state_nx   = ST_MARK_RD;
				end else begin
					state_nx = ST_RESP;
				end
			end
			ST_MARK_RD: begin
				if (stat.mark_row_ok) begin
					cmd.mark_rd = 1'b1;
					state_nx    = ST_MARK_WR;
				end else begin
					state_nx = ST_RESP;
				end
			end
			ST_MARK_WR: begin
				cmd.mark_wr = 1'b1;
				cmd.row_inc = 1'b1;
				state_nx    = ST_MARK_RD;
			end
			ST_FIND_ROW: begin
				if (stat.grid_done) begin
					if (stat.last_grid) begin
						state_nx = ST_RESP;
					end else begin
						cmd.grid_next = 1'b1;
					end
				end else begin
					cmd.find_start = 1'b1;
					state_nx       = ST_FIND_RD;
				end
			end
			ST_FIND_RD: begin
				cmd.find_rd = 1'b1;
				state_nx    = ST_FIND_ACC;
			end
			ST_FIND_ACC: begin
				cmd.find_acc = 1'b1;
				state_nx     = stat.acc_more ? ST_FIND_RD : ST_FIND_EVAL;
			end
			ST_FIND_EVAL: begin
				if (stat.fit_any) begin
					cmd.set_hit = 1'b1;
					state_nx    = ST_RESP;
				end else begin
					cmd.row_inc = 1'b1;
					state_nx    = ST_FIND_ROW;
				end
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/core/gofa_dp.sv
// Datapath of the grid occupancy allocator: config registers, occupancy
// memory with row valid bits, scan counters, fit logic, output register.
// Depends on gofa_pkg.
module gofa_dp import gofa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic [0:0]             m_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  gofa_cmd_t              cmd,
	output gofa_stat_t             stat
);

	gofa_in_t in_w;
	gofa_out_t out_w;

	logic [DIM_W-1:0]  rows_cfg_q [NUM_GRIDS];
	logic [DIM_W-1:0]  cols_cfg_q [NUM_GRIDS];
	logic [DIM_W-1:0]  eff_rows   [NUM_GRIDS];
	logic [DIM_W-1:0]  eff_cols   [NUM_GRIDS];

	gofa_req_t         type_q;
	logic [GRID_W-1:0] tg_q;
	logic [ROW_W-1:0]  tr_q;
	logic [COL_W-1:0]  tc_q;
	logic [DIM_W-1:0]  h_q, w_q;

	logic [GRID_W-1:0] grid_q;
	logic [DIM_W-1:0]  row_q, rr_q;
	logic [MAX_COLS-1:0] acc_q, base_q;

	logic              res_ok_q;
	logic [GRID_W-1:0] res_grid_q;
	logic [ROW_W-1:0]  res_row_q;
	logic [COL_W-1:0]  res_col_q;

	logic              out_valid_q, out_ok_q;
	logic [GRID_W-1:0] out_grid_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;

	logic [MAX_COLS-1:0] mem [DEPTH];
	logic [DEPTH-1:0]    valid_q;
	logic [MAX_COLS-1:0] rd_data_q;
	logic                rd_vld_q;
	logic [MAX_COLS-1:0] rd_word, wr_word, mark_mask, w_mask, fit_vec;
	logic [ADDR_W-1:0]   rd_addr, wr_addr;
	logic                mem_re;
	logic [GRID_W-1:0]   cfg_grid;

	logic [DIM_W-1:0]  rows_t, cols_t, rows_g, cols_g;
	logic [DIM_W:0]    tr_sum, tc_sum, rend, cend, frow, row_h, rr_nx;
	logic              nz;
	logic [COL_W-1:0]  fit_col;

	assign in_w = gofa_in_t'(s_tdata);

	// effective grid sizes
	always_comb begin
		for (int g = 0; g < NUM_GRIDS; g++) begin
			eff_rows[g] = clamp_dim(rows_cfg_q[g], DIM_W'(MAX_ROWS));
			eff_cols[g] = clamp_dim(cols_cfg_q[g], DIM_W'(MAX_COLS));
		end
	end

	assign cfg_grid = cfg_index[CFG_IDX_W-1:1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g < NUM_GRIDS; g++) begin
				rows_cfg_q[g] <= '0;
				cols_cfg_q[g] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index[0]) begin
				cols_cfg_q[cfg_grid] <= cfg_data;
			end else begin
				rows_cfg_q[cfg_grid] <= cfg_data;
			end
		end
	end

	// captured request
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			type_q <= gofa_req_t'(s_tuser);
			tg_q   <= in_w.target_grid;
			tr_q   <= in_w.target_row;
			tc_q   <= in_w.target_col;
			h_q    <= in_w.item_rows;
			w_q    <= in_w.item_cols;
		end
	end

	// mark/free rectangle bounds, clipped to the target grid
	assign rows_t = eff_rows[tg_q];
	assign cols_t = eff_cols[tg_q];
	assign tr_sum = {2'b00, tr_q} + {1'b0, h_q};
	assign tc_sum = {2'b00, tc_q} + {1'b0, w_q};
	assign rend   = (tr_sum > {1'b0, rows_t}) ? {1'b0, rows_t} : tr_sum;
	assign cend   = (tc_sum > {1'b0, cols_t}) ? {1'b0, cols_t} : tc_sum;

	always_comb begin
		for (int k = 0; k < MAX_COLS; k++) begin
			mark_mask[k] = ((DIM_W+1)'(k) >= {2'b00, tc_q}) && ((DIM_W+1)'(k) < cend);
		end
	end

	// scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q <= '0;
			row_q  <= '0;
			rr_q   <= '0;
		end else begin
			if (cmd.load_req) begin
				grid_q <= '0;
				row_q  <= (gofa_req_t'(s_tuser) == REQ_FIND) ? '0 : {1'b0, in_w.target_row};
			end else if (cmd.grid_next) begin
				grid_q <= grid_q + 1'b1;
				row_q  <= '0;
			end else if (cmd.row_inc) begin
				row_q <= row_q + 1'b1;
			end
			if (cmd.find_start) begin
				rr_q <= '0;
			end else if (cmd.find_acc) begin
				rr_q <= rr_nx[DIM_W-1:0];
			end
		end
	end

	// find: OR of the rows under the candidate start row
	always_ff @(posedge clk) begin
		if (cmd.find_start) begin
			acc_q <= '0;
		end else if (cmd.find_acc) begin
			acc_q <= acc_q | rd_word;
			if (rr_q == '0) begin
				base_q <= rd_word;
			end
		end
	end

	assign rows_g = eff_rows[grid_q];
	assign cols_g = eff_cols[grid_q];
	assign nz     = (h_q != '0) && (w_q != '0);
	assign row_h  = {1'b0, row_q} + {1'b0, h_q};
	assign frow   = {1'b0, row_q} + {1'b0, rr_q};
	assign rr_nx  = {1'b0, rr_q} + 1'b1;
	assign w_mask = ~({MAX_COLS{1'b1}} << w_q);

	// per-column fit test and first-fit pick
	always_comb begin
		fit_col = '0;
		for (int c = 0; c < MAX_COLS; c++) begin
			if (nz) begin
				fit_vec[c] = !base_q[c]
					&& (((DIM_W+1)'(c) + {1'b0, w_q}) <= {1'b0, cols_g})
					&& (((acc_q >> c) & w_mask) == '0);
			end else begin
				fit_vec[c] = !base_q[c] && (DIM_W'(c) < cols_g);
			end
		end
		for (int c = MAX_COLS - 1; c >= 0; c--) begin
			if (fit_vec[c]) begin
				fit_col = COL_W'(c);
			end
		end
	end

	// occupancy memory
	assign mem_re  = cmd.mark_rd | cmd.find_rd;
	assign rd_addr = cmd.find_rd ? {grid_q, frow[ROW_W-1:0]} : {tg_q, row_q[ROW_W-1:0]};
	assign wr_addr = {tg_q, row_q[ROW_W-1:0]};
	assign rd_word = rd_vld_q ? rd_data_q : '0;
	assign wr_word = (type_q == REQ_MARK) ? (rd_word | mark_mask) : (rd_word & ~mark_mask);

	always_ff @(posedge clk) begin
		if (cmd.mark_wr) begin
			mem[wr_addr] <= wr_word;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// row valid bits: an invalid row reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_re) begin
				rd_vld_q <= valid_q[rd_addr];
			end
			if (cmd.clear_all) begin
				valid_q <= '0;
			end else if (cfg_we) begin
				for (int r = 0; r < MAX_ROWS; r++) begin
					valid_q[{cfg_grid, ROW_W'(r)}] <= 1'b0;
				end
			end else if (cmd.mark_wr) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	// result being built; clear sets ok together with the load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ok_q <= 1'b0;
		end else if (cmd.load_req) begin
			res_ok_q <= cmd.set_ok;
		end else if (cmd.set_ok || cmd.set_hit) begin
			res_ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			res_grid_q <= '0;
			res_row_q  <= '0;
			res_col_q  <= '0;
		end else if (cmd.set_hit) begin
			res_grid_q <= grid_q;
			res_row_q  <= row_q[ROW_W-1:0];
			res_col_q  <= fit_col;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_ok_q   <= res_ok_q;
			out_grid_q <= res_grid_q;
			out_row_q  <= res_row_q;
			out_col_q  <= res_col_q;
		end
	end

	assign out_w.pad        = '0;
	assign out_w.found_grid = out_grid_q;
	assign out_w.found_row  = out_row_q;
	assign out_w.found_col  = out_col_q;
	assign m_tdata  = OUT_TDATA_W'(out_w);
	assign m_tuser  = out_ok_q;
	assign m_tvalid = out_valid_q;

	// status to controller
	assign stat.tgt_present = (rows_t != '0) && (cols_t != '0);
	assign stat.mark_row_ok = {1'b0, row_q} < rend;
	assign stat.grid_done   = (rows_g == '0) || (cols_g == '0) || (row_q >= rows_g)
		|| (nz && (row_h > {1'b0, rows_g}));
	assign stat.last_grid   = (grid_q == GRID_W'(NUM_GRIDS - 1));
	assign stat.acc_more    = nz && (rr_nx < {1'b0, h_q});
	assign stat.fit_any     = |fit_vec;
	assign stat.out_free    = !out_valid_q || m_tready;

endmodule

>>> rtl/core/grid_occupancy_first_fit_allocator_unit.sv
// First-fit rectangle allocator over an occupancy bitmap of up to four grids
// of at most 16x16 cells, each sized by a rows and a cols register (zero means
// absent; writing either register frees that grid). A request marks a
// rectangle occupied or free (clipped to the grid), clears everything, or
// finds the first free cell in grid then row-major order where the rectangle
// fits. One request is worked at a time; the next one is taken while the
// previous result still waits in the output register. All timing comes from
// the single read port of the 64-row occupancy memory: clear touches no row,
// mark/free reads and rewrites each clipped row in turn (none for an absent
// grid), and a find reads h rows per candidate start row, grid by grid
// (h = item_rows, 1 if either size is zero).
// No clearing pass: per-row valid bits make reset and clear immediate.
// Depends on gofa_pkg, gofa_ctrl, gofa_dp and the macros header.
`include "grid_occupancy_first_fit_allocator_unit_macros.svh"

module grid_occupancy_first_fit_allocator_unit import gofa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// target_grid, target_row, target_col, item_rows, item_cols
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// req_type
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// found_grid, found_row, found_col
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// ok
	output logic [0:0]             m_tuser,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	gofa_cmd_t  ctl_cmd;
	gofa_stat_t dp_stat;

	gofa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (dp_stat),
		.cmd      (ctl_cmd)
	);

	gofa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (ctl_cmd),
		.stat      (dp_stat)
	);

	// one request in flight: accepting closes the input for the next cycle
	`GOFA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second request taken while busy")
	// a waiting result is never overwritten
	`GOFA_ASSERT_SAME(a_no_overwrite, ctl_cmd.load_out, !m_tvalid || m_tready, "result overwritten")
	// a result without ok carries a zero position
	`GOFA_ASSERT_SAME(a_zero_on_miss, m_tvalid && !m_tuser[0], m_tdata == '0, "position set on miss")

endmodule
